// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the filter chain top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/qpf_pkg.sv -----
package qpf_pkg;

  localparam int DEF_WINDOW_LEN  = 32;
  localparam int DEF_SAMPLE_BITS = 12;

  // Result field widths.
  localparam int BP_W    = 14;
  localparam int SLOPE_W = 13;
  localparam int SQ_W    = 24;
  localparam int INT_W   = 24;
  localparam int OUT_FIELDS_W = BP_W + SLOPE_W + SQ_W + INT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Filter geometry.
  localparam int LP_TAPS      = 12;
  localparam int LP_NOTCH_LAG = 6;
  localparam int HP_TAPS      = 32;
  localparam int HP_DELAY     = 15;
  localparam int DV_TAPS      = 4;

  localparam int LP_SHIFT  = 5;
  localparam int HP_SHIFT  = 5;
  localparam int DV_SHIFT  = 3;
  localparam int INT_SHIFT = 5;

  localparam logic [SQ_W-1:0] SQ_MAX = '1;

endpackage

// ----- hw/rtl/qpf_lowpass.sv -----
module qpf_lowpass #(
  parameter int SAMPLE_BITS = qpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   out_lp
);
  import qpf_pkg::*;

  // The unshifted output is bounded by 36 times the largest sample.
  localparam int LPW = SAMPLE_BITS + 7;
  localparam int LPO = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] xd [LP_TAPS];
  logic signed [LPW-1:0]         y1;
  logic signed [LPW-1:0]         y2;
  logic signed [LPW-1:0]         y_next;
  logic                          load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Wrap-around arithmetic is exact because the true result fits in LPW bits.
  always_comb begin
    y_next = (y1 <<< 1) - y2 + LPW'(in_sample)
           - (LPW'(xd[LP_NOTCH_LAG-1]) <<< 1) + LPW'(xd[LP_TAPS-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      y1        <= '0;
      y2        <= '0;
      for (int i = 0; i < LP_TAPS; i++) begin
        xd[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        y2        <= y1;
        y1        <= y_next;
        xd[0]     <= in_sample;
        for (int i = 1; i < LP_TAPS; i++) begin
          xd[i] <= xd[i-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_lp <= LPO'(y_next >>> LP_SHIFT);
    end
  end

endmodule

// ----- hw/rtl/qpf_highpass.sv -----
module qpf_highpass #(
  parameter int SAMPLE_BITS = qpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS:0]      in_lp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [qpf_pkg::BP_W-1:0]  out_bp
);
  import qpf_pkg::*;

  localparam int LPO = SAMPLE_BITS + 1;
  localparam int HSW = SAMPLE_BITS + 6;
  localparam int HFW = SAMPLE_BITS + 2;
  localparam int HCW = (HFW > BP_W) ? HFW : BP_W;
  localparam logic signed [HCW-1:0] HP_HI = HCW'(2 ** (BP_W - 1) - 1);
  localparam logic signed [HCW-1:0] HP_LO = -HP_HI - HCW'(1);

  logic signed [LPO-1:0]  ld [HP_TAPS];
  logic signed [HSW-1:0]  sum;
  logic signed [HSW-1:0]  sum_next;
  logic signed [HFW-1:0]  hp_full;
  logic signed [HCW-1:0]  hp_ext;
  logic signed [BP_W-1:0] hp_sat;
  logic                   load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    sum_next = sum + HSW'(in_lp) - HSW'(ld[HP_TAPS-1]);
    hp_full  = HFW'(ld[HP_DELAY-1]) - HFW'(sum_next >>> HP_SHIFT);
    hp_ext   = HCW'(hp_full);
    if (hp_ext > HP_HI) begin
      hp_sat = BP_W'(HP_HI);
    end else if (hp_ext < HP_LO) begin
      hp_sat = BP_W'(HP_LO);
    end else begin
      hp_sat = BP_W'(hp_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum       <= '0;
      for (int i = 0; i < HP_TAPS; i++) begin
        ld[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sum       <= sum_next;
        ld[0]     <= in_lp;
        for (int i = 1; i < HP_TAPS; i++) begin
          ld[i] <= ld[i-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bp <= hp_sat;
    end
  end

endmodule

// ----- hw/rtl/qpf_slope.sv -----
module qpf_slope (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qpf_pkg::BP_W-1:0]    in_bp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qpf_pkg::BP_W-1:0]    out_bp,
  output logic signed [qpf_pkg::SLOPE_W-1:0] out_slope
);
  import qpf_pkg::*;

  localparam int DVW = BP_W + 3;
  localparam logic signed [DVW-1:0] DV_HI = DVW'(2 ** (SLOPE_W - 1) - 1);
  localparam logic signed [DVW-1:0] DV_LO = -DV_HI - DVW'(1);

  logic signed [BP_W-1:0]    dd [DV_TAPS];
  logic signed [DVW-1:0]     dv;
  logic signed [DVW-1:0]     dv_sh;
  logic signed [SLOPE_W-1:0] dv_sat;
  logic                      load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    dv = (DVW'(in_bp) <<< 1) + DVW'(dd[0]) - DVW'(dd[DV_TAPS-2])
       - (DVW'(dd[DV_TAPS-1]) <<< 1);
    dv_sh = dv >>> DV_SHIFT;
    if (dv_sh > DV_HI) begin
      dv_sat = SLOPE_W'(DV_HI);
    end else if (dv_sh < DV_LO) begin
      dv_sat = SLOPE_W'(DV_LO);
    end else begin
      dv_sat = SLOPE_W'(dv_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < DV_TAPS; i++) begin
        dd[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        dd[0]     <= in_bp;
        for (int i = 1; i < DV_TAPS; i++) begin
          dd[i] <= dd[i-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bp    <= in_bp;
      out_slope <= dv_sat;
    end
  end

endmodule

// ----- hw/rtl/qpf_integrate.sv -----
module qpf_integrate #(
  parameter int WINDOW_LEN = qpf_pkg::DEF_WINDOW_LEN
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qpf_pkg::BP_W-1:0]    in_bp,
  input  logic signed [qpf_pkg::SLOPE_W-1:0] in_slope,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qpf_pkg::BP_W-1:0]    out_bp,
  output logic signed [qpf_pkg::SLOPE_W-1:0] out_slope,
  output logic        [qpf_pkg::SQ_W-1:0]    out_sq,
  output logic        [qpf_pkg::INT_W-1:0]   out_int
);
  import qpf_pkg::*;

  localparam int PW   = 2 * SLOPE_W;
  localparam int SUMW = SQ_W + $clog2(WINDOW_LEN);
  localparam int SUMX = (SUMW > SQ_W + INT_SHIFT) ? SUMW : SQ_W + INT_SHIFT;

  // Square stage
  logic                      sq_valid;
  logic                      sq_ready;
  logic signed [BP_W-1:0]    sq_bp;
  logic signed [SLOPE_W-1:0] sq_slope;
  logic [SQ_W-1:0]           sq_val;
  logic signed [PW-1:0]      prod;
  logic [SQ_W-1:0]           prod_sat;
  logic                      sq_load;

  // Window stage
  logic [SQ_W-1:0]  ws [WINDOW_LEN];
  logic [SUMW-1:0]  sum;
  logic [SUMW-1:0]  sum_next;
  logic [SUMX-1:0]  sum_sh;
  logic [INT_W-1:0] int_sat;
  logic             win_load;

  assign in_ready = !sq_valid || sq_ready;
  assign sq_load  = in_valid && in_ready;
  assign sq_ready = !out_valid || out_ready;
  assign win_load = sq_valid && sq_ready;

  always_comb begin
    prod = PW'(in_slope) * PW'(in_slope);
    if (prod > PW'(SQ_MAX)) begin
      prod_sat = SQ_MAX;
    end else begin
      prod_sat = prod[SQ_W-1:0];
    end
  end

  always_comb begin
    sum_next = sum - SUMW'(ws[WINDOW_LEN-1]) + SUMW'(sq_val);
    sum_sh   = SUMX'(sum_next) >> INT_SHIFT;
    if (sum_sh > SUMX'(SQ_MAX)) begin
      int_sat = SQ_MAX;
    end else begin
      int_sat = sum_sh[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      out_valid <= 1'b0;
      sum       <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ws[i] <= '0;
      end
    end else begin
      if (sq_load) begin
        sq_valid <= 1'b1;
      end else if (sq_ready) begin
        sq_valid <= 1'b0;
      end
      if (win_load) begin
        out_valid <= 1'b1;
        sum       <= sum_next;
        ws[0]     <= sq_val;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          ws[i] <= ws[i-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_load) begin
      sq_bp    <= in_bp;
      sq_slope <= in_slope;
      sq_val   <= prod_sat;
    end
    if (win_load) begin
      out_bp    <= sq_bp;
      out_slope <= sq_slope;
      out_sq    <= sq_val;
      out_int   <= int_sat;
    end
  end

endmodule

// ----- hw/rtl/qrs_preprocess_filter_chain_top.sv -----
// Channel   Direction  Contents
// s_*       in         one ECG sample per item (tdata: sample)
// m_*       out        one result per item (tdata: bandpassed, slope, squared, integrated)
//
// One item is accepted per clock unless a stalled output has filled the pipeline. A result is
// registered by each stage in turn before it is offered on m_*.
// The chain is a pipeline of five registered stages: low pass, high pass,
// derivative, squaring and the moving-window sum. Each stage holds its item until
// the next stage can take it, so a stalled output fills the pipeline before
// s_tready drops. Synchronous reset clears all delay lines, sums and valid flags.
`include "assert_macros.svh"

module qrs_preprocess_filter_chain_top #(
  parameter int WINDOW_LEN  = qpf_pkg::DEF_WINDOW_LEN,
  parameter int SAMPLE_BITS = qpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata, from bit 0 up: sample, then zero fill to a whole byte
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata, from bit 0 up: bandpassed, slope, squared, integrated, zero fill
  output logic [qpf_pkg::OUT_TDATA_W-1:0]        m_tdata
);
  import qpf_pkg::*;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};

  // Only the low SAMPLE_BITS bits of tdata carry the sample.
  logic signed [SAMPLE_BITS-1:0] sample;
  assign sample = s_tdata[SAMPLE_BITS-1:0];

  // Stage hand-offs.
  logic                        lp_valid;
  logic                        lp_ready;
  logic signed [SAMPLE_BITS:0] lp_data;
  logic                        hp_valid;
  logic                        hp_ready;
  logic signed [BP_W-1:0]      hp_data;
  logic                        dv_valid;
  logic                        dv_ready;
  logic signed [BP_W-1:0]      dv_bp;
  logic signed [SLOPE_W-1:0]   dv_slope;

  // Result fields.
  logic signed [BP_W-1:0]    bandpassed;
  logic signed [SLOPE_W-1:0] slope;
  logic [SQ_W-1:0]           squared;
  logic [INT_W-1:0]          integrated;

  // Recursive low pass on the raw sample.
  qpf_lowpass #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lowpass (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_sample(sample),
    .out_valid(lp_valid),
    .out_ready(lp_ready),
    .out_lp   (lp_data)
  );

  // Delayed input minus the 32-item running mean, saturated to 14 bits.
  qpf_highpass #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_highpass (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lp_valid),
    .in_ready (lp_ready),
    .in_lp    (lp_data),
    .out_valid(hp_valid),
    .out_ready(hp_ready),
    .out_bp   (hp_data)
  );

  // Five-point derivative divided by eight.
  qpf_slope u_slope (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hp_valid),
    .in_ready (hp_ready),
    .in_bp    (hp_data),
    .out_valid(dv_valid),
    .out_ready(dv_ready),
    .out_bp   (dv_bp),
    .out_slope(dv_slope)
  );

  // Squaring then the moving-window sum; its last register is the output register.
  qpf_integrate #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_integrate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv_valid),
    .in_ready (dv_ready),
    .in_bp    (dv_bp),
    .in_slope (dv_slope),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_bp   (bandpassed),
    .out_slope(slope),
    .out_sq   (squared),
    .out_int  (integrated)
  );

  assign m_tdata = OUT_TDATA_W'({integrated, squared, slope, bandpassed});

  // The input can only be refused when every stage is full behind a stalled output.
  `ASSERT_SAME(a_full_only_on_stall, clk, rst, !s_tready, m_tvalid && !m_tready, "input refused without output stall")
  // An accepted item is always held by the first stage in the following cycle.
  `ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, lp_valid, "accepted item lost in low pass stage")
  // The squared field must match the delivered slope.
  `ASSERT_SAME(a_square_matches, clk, rst, m_tvalid, (slope == SLOPE_MIN && squared == SQ_MAX) || squared == SQ_W'(SQ_W'(slope) * SQ_W'(slope)), "squared field does not match slope")

endmodule
